// ===== rtl/core/tccw_pkg.sv =====
// Package for the text console character writer.
// Holds geometry constants, codes, item types and helper functions.
// Depends on nothing.
`timescale 1ns / 1ps

package tccw_pkg;

  localparam int COLUMNS = 40;
  localparam int ROWS    = 24;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 5;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(CELLS + 1);

  localparam logic [7:0] CHAR_CR  = 8'h0d;
  localparam logic [7:0] CHAR_LF  = 8'h0a;
  localparam logic [7:0] CHAR_EOL = 8'h9b;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GOTO  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] REG_REVERSE = 2'd0;
  localparam logic [1:0] REG_CURSOR  = 2'd1;
  localparam logic [1:0] REG_SCROLL  = 2'd2;

  typedef enum logic [2:0] {
    K_CR, K_LF, K_CHAR, K_GOTO, K_CLEAR, K_READ
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_SWEEP, ST_READ, ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]       command;
    logic [7:0]       char_code;
    logic [COL_W-1:0] target_col;
    logic [ROW_W-1:0] target_row;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_value;
    logic             cursor_hidden;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    kind_e            kind;
    logic [7:0]       char_code;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             in_range;
  } op_t;

  typedef struct packed {
    logic reverse_video;
    logic cursor_enable;
    logic scroll_enable;
  } cfg_t;

  function automatic logic [ADDR_W-1:0] cell_addr(logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(row);
    return ADDR_W'(r * ADDR_W'(COLUMNS)) + ADDR_W'(col);
  endfunction

  function automatic logic [7:0] screen_code(logic [7:0] c, logic rev);
    logic [7:0] orv;
    unique case (c[6:5])
      2'd0: orv = 8'h40;
      2'd1: orv = 8'h00;
      2'd2: orv = 8'h20;
      default: orv = 8'h60;
    endcase
    return (c & 8'h9f) | orv | {rev, 7'b0};
  endfunction

endpackage

// ===== rtl/core/tccw_front.sv =====
// Front end: accepts commands, classifies them, queues them for the back end.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_front import tccw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  in_item_t cmd_i,
  input  logic     hold_i,
  output logic     busy_o,
  output logic     op_valid_o,
  output op_t      op_o,
  input  logic     op_pop_i
);

  op_t        fifo_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;
  op_t        op_new;

  assign busy_o     = (cnt_q == 2'd2) || hold_i;
  assign push       = start_i && !busy_o;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o       = fifo_q[rd_q];

  always_comb begin
    op_new.char_code = cmd_i.char_code;
    op_new.col       = cmd_i.target_col;
    op_new.row       = cmd_i.target_row;
    op_new.in_range  = (cmd_i.target_col < COL_W'(COLUMNS)) &&
                       (cmd_i.target_row < ROW_W'(ROWS));
    op_new.kind      = K_CHAR;
    unique case (cmd_i.command)
      CMD_PUT: begin
        if (cmd_i.char_code == CHAR_CR) begin
          op_new.kind = K_CR;
        end else if (cmd_i.char_code == CHAR_LF || cmd_i.char_code == CHAR_EOL) begin
          op_new.kind = K_LF;
        end else begin
          op_new.kind = K_CHAR;
        end
      end
      CMD_GOTO: begin
        op_new.kind = K_GOTO;
        if (cmd_i.target_col >= COL_W'(COLUMNS)) op_new.col = COL_W'(COLUMNS - 1);
        if (cmd_i.target_row >= ROW_W'(ROWS)) op_new.row = ROW_W'(ROWS - 1);
      end
      CMD_CLEAR: op_new.kind = K_CLEAR;
      default:   op_new.kind = K_READ;
    endcase
  end

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = op_pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, op_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= op_new;
  end

endmodule

// ===== rtl/core/tccw_back.sv =====
// Back end: sequencer and screen store; runs queued commands, emits results.
// Depends on tccw_pkg.
`timescale 1ns / 1ps

module tccw_back import tccw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  output logic      init_o,
  output logic      done_o,
  output out_item_t res_o
);

  // store holds true bytes; the cursor is overlaid on reads
  logic [7:0] mem [CELLS];
  logic [7:0] rdata_q;

  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d, rc_q, rc_d;
  logic [ROW_W-1:0]  row_q, row_d, rr_q, rr_d;
  logic              inhibit_q, inhibit_d, drawn_q, drawn_d;
  logic              init_q, init_d, clr_q, clr_d, inr_q, inr_d;
  logic [CNT_W-1:0]  p_q, p_d;
  logic [7:0]        cell_q, cell_d;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr, p_lo, p_m1;
  logic [7:0]        wdata;

  assign init_o = init_q;
  assign p_lo   = p_q[ADDR_W-1:0];
  assign p_m1   = p_lo - ADDR_W'(1);

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    rc_d      = rc_q;
    rr_d      = rr_q;
    inhibit_d = inhibit_q;
    drawn_d   = drawn_q;
    init_d    = init_q;
    clr_d     = clr_q;
    inr_d     = inr_q;
    p_d       = p_q;
    cell_d    = cell_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = cell_addr(col_q, row_q);
    raddr     = cell_addr(op_i.col, op_i.row);
    wdata     = screen_code(op_i.char_code, cfg_i.reverse_video);
    op_pop_o  = 1'b0;
    done_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i && !init_q) begin
          logic nl;
          nl       = 1'b0;
          op_pop_o = 1'b1;
          cell_d   = 8'h00;
          state_d  = ST_RESP;
          if (op_i.kind != K_READ) begin
            inhibit_d = !cfg_i.cursor_enable;
            drawn_d   = cfg_i.cursor_enable;
          end
          unique case (op_i.kind)
            K_CR: col_d = '0;
            K_LF: begin
              col_d = '0;
              nl    = 1'b1;
            end
            K_CHAR: begin
              we = 1'b1;
              if (col_q == COL_W'(COLUMNS - 1)) begin
                col_d = '0;
                nl    = 1'b1;
              end else begin
                col_d = col_q + COL_W'(1);
              end
            end
            K_GOTO: begin
              col_d = op_i.col;
              row_d = op_i.row;
            end
            K_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              clr_d   = 1'b1;
              p_d     = '0;
              state_d = ST_SWEEP;
            end
            default: begin
              re      = op_i.in_range;
              inr_d   = op_i.in_range;
              rc_d    = op_i.col;
              rr_d    = op_i.row;
              state_d = ST_READ;
            end
          endcase
          if (nl) begin
            if (row_q == ROW_W'(ROWS - 1)) begin
              if (cfg_i.scroll_enable) begin
                clr_d   = 1'b0;
                p_d     = '0;
                state_d = ST_SWEEP;
              end else begin
                row_d = '0;
                col_d = '0;
              end
            end else begin
              row_d = row_q + ROW_W'(1);
            end
          end
        end
      end
      ST_SWEEP: begin
        // read one row ahead, write the previous cycle's data one step behind
        re    = !clr_q && (p_q < CNT_W'(CELLS - COLUMNS));
        raddr = p_lo + ADDR_W'(COLUMNS);
        we    = (p_q != '0);
        waddr = p_m1;
        wdata = (clr_q || (p_m1 >= ADDR_W'(CELLS - COLUMNS))) ? 8'h00 : rdata_q;
        p_d   = p_q + CNT_W'(1);
        if (p_q == CNT_W'(CELLS)) begin
          p_d     = p_q;
          init_d  = 1'b0;
          state_d = init_q ? ST_IDLE : ST_RESP;
        end
      end
      ST_READ: begin
        cell_d  = inr_q ? (rdata_q ^ {drawn_q && rc_q == col_q && rr_q == row_q, 7'b0})
                        : 8'h00;
        state_d = ST_RESP;
      end
      default: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o.cursor_col    = col_q;
  assign res_o.cursor_row    = row_q;
  assign res_o.cell_value    = cell_q;
  assign res_o.cursor_hidden = inhibit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_SWEEP;
      col_q     <= '0;
      row_q     <= '0;
      inhibit_q <= 1'b0;
      drawn_q   <= 1'b0;
      init_q    <= 1'b1;
      clr_q     <= 1'b1;
      p_q       <= '0;
    end else begin
      state_q   <= state_d;
      col_q     <= col_d;
      row_q     <= row_d;
      inhibit_q <= inhibit_d;
      drawn_q   <= drawn_d;
      init_q    <= init_d;
      clr_q     <= clr_d;
      p_q       <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rc_q   <= rc_d;
    rr_q   <= rr_d;
    inr_q  <= inr_d;
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

endmodule

// ===== rtl/core/text_console_char_writer_top.sv =====
// Top level of the text console character writer.
// Depends on tccw_pkg, tccw_front and tccw_back.
//
// Usage:
//  - Command channel: a transaction is taken at a rising edge with start_i
//    high and busy_o low; cmd_i carries command, char, target column/row.
//  - Result channel: done_o is high for exactly one cycle per command with
//    res_o valid; the receiver cannot stall it.
//  - Config channel: cfg_valid_i/cfg_ready_o (always ready), cfg_index_i
//    selects reverse_video, cursor_enable, scroll_enable; bit 0 of
//    cfg_data_i is written. Write only while idle.
//  - Put_char and goto pass the back end's ST_IDLE (execute) and then
//    ST_RESP; read_cell adds ST_READ for the registered store read.
//    Clear and a scrolling new line run a sweep over the 960-cell store,
//    one cell per cycle on the store's single write port.
//  - The back end sequencer takes no new command until the last one has
//    given its result (execute, then result state).
//  - A two-entry queue sits between the front end and the back end, so
//    commands are taken while the back end is busy until it fills.
//  - Reset: a clearing pass zeroes the store; busy_o stays high until it
//    ends. Config registers may be written during it.
`timescale 1ns / 1ps

module text_console_char_writer_top import tccw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  cmd_i,
  output logic      busy_o,
  output logic      done_o,
  output out_item_t res_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic      cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic op_valid, op_pop, init;
  op_t  op;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_REVERSE: cfg_d.reverse_video = cfg_data_i;
        REG_CURSOR:  cfg_d.cursor_enable = cfg_data_i;
        REG_SCROLL:  cfg_d.scroll_enable = cfg_data_i;
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{reverse_video: 1'b0, cursor_enable: 1'b1, scroll_enable: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tccw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .hold_i     (init),
    .busy_o     (busy_o),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  tccw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (op_valid),
    .op_i       (op),
    .op_pop_o   (op_pop),
    .init_o     (init),
    .done_o     (done_o),
    .res_o      (res_o)
  );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for text_console_char_writer_top.
// Mirrors the screen store, cursor and saved cell, predicts one result per
// command and checks each done_o strobe. Depends on tccw_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import tccw_pkg::*;

  // Mirror of the console and per-result check.
  class console_scoreboard;
    logic [7:0]       scr [CELLS];
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [7:0]       under;
    int unsigned      under_at;
    logic             hidden;
    cfg_t             cfg;
    out_item_t        pending[$];
    int               errors;

    function new();
      foreach (scr[i]) scr[i] = 8'h00;
      col = '0; row = '0; under = 8'h00; under_at = 0; hidden = 1'b0;
      cfg = '{reverse_video: 1'b0, cursor_enable: 1'b1, scroll_enable: 1'b1};
      errors = 0;
    endfunction

    function int unsigned addr_of(int unsigned c, int unsigned r);
      int unsigned a;
      a = r * COLUMNS + c;
      return (a < CELLS) ? a : 0;
    endfunction

    function void restore_under();
      if (under_at < CELLS) scr[under_at] = under;
    endfunction

    // Remember true byte under the cursor, then draw the cursor.
    function void draw_cursor(bit restore);
      int unsigned a;
      logic [7:0] v;
      if (restore) restore_under();
      a = addr_of(col, row);
      v = scr[a];
      under = v;
      under_at = a;
      if (cfg.cursor_enable) begin
        hidden = 1'b0;
        v = v ^ 8'h80;
      end else begin
        hidden = 1'b1;
      end
      scr[a] = v;
    endfunction

    function void new_line();
      if (int'(row) + 1 >= ROWS) begin
        if (cfg.scroll_enable) begin
          restore_under();
          for (int i = 0; i < CELLS - COLUMNS; i++) scr[i] = scr[i + COLUMNS];
          for (int i = CELLS - COLUMNS; i < CELLS; i++) scr[i] = 8'h00;
          row = ROW_W'(ROWS - 1);
          draw_cursor(1'b0);
          return;
        end
        row = '0;
        col = '0;
      end else begin
        row = row + 1'b1;
      end
      draw_cursor(1'b1);
    endfunction

    function void put_char(logic [7:0] c);
      logic [7:0] code;
      logic [7:0] lead;
      if (c == CHAR_CR) begin
        col = '0;
        draw_cursor(1'b1);
      end else if (c == CHAR_LF || c == CHAR_EOL) begin
        col = '0;
        new_line();
      end else begin
        case (c[6:5])
          2'd0: lead = 8'h40;
          2'd1: lead = 8'h00;
          2'd2: lead = 8'h20;
          default: lead = 8'h60;
        endcase
        code = (c & 8'h9f) | lead | (cfg.reverse_video ? 8'h80 : 8'h00);
        restore_under();
        under_at = addr_of(col, row);
        scr[under_at] = code;
        under = code;
        if (int'(col) + 1 >= COLUMNS) begin
          col = '0;
          new_line();
        end else begin
          col = col + 1'b1;
          draw_cursor(1'b1);
        end
      end
    endfunction

    function void note_command(in_item_t it);
      out_item_t r;
      r.cell_value = 8'h00;
      case (it.command)
        CMD_PUT: put_char(it.char_code);
        CMD_GOTO: begin
          col = (it.target_col < COLUMNS) ? it.target_col : COL_W'(COLUMNS - 1);
          row = (it.target_row < ROWS) ? it.target_row : ROW_W'(ROWS - 1);
          draw_cursor(1'b1);
        end
        CMD_CLEAR: begin
          foreach (scr[i]) scr[i] = 8'h00;
          under = 8'h00;
          col = '0;
          row = '0;
          draw_cursor(1'b1);
        end
        default: begin
          if (it.target_col < COLUMNS && it.target_row < ROWS)
            r.cell_value = scr[addr_of(it.target_col, it.target_row)];
        end
      endcase
      r.cursor_col = col;
      r.cursor_row = row;
      r.cursor_hidden = hidden;
      pending.push_back(r);
    endfunction

    function void report(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got, 0);
        return;
      end
      want = pending.pop_front();
      if (got.cursor_col !== want.cursor_col)
        report("cursor_col", got.cursor_col, want.cursor_col);
      if (got.cursor_row !== want.cursor_row)
        report("cursor_row", got.cursor_row, want.cursor_row);
      if (got.cell_value !== want.cell_value)
        report("cell_value", got.cell_value, want.cell_value);
      if (got.cursor_hidden !== want.cursor_hidden)
        report("cursor_hidden", got.cursor_hidden, want.cursor_hidden);
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  in_item_t   cmd_i = '0;
  logic       busy_o;
  logic       done_o;
  out_item_t  res_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = REG_REVERSE;
  logic       cfg_data_i = 1'b0;

  console_scoreboard board;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  text_console_char_writer_top DUT (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o, .done_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // Results cannot be held off: sample every strobe.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(res_o);
  end

  // Mostly short gaps, sometimes long ones, sometimes back to back.
  // start_i is only dropped when an idle gap follows.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 40) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // One command transaction; scoreboard is updated at the accepting edge.
  task automatic send_command(logic [1:0] op, logic [7:0] ch,
                              logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                              bit gaps = 1'b1);
    in_item_t it;
    it = '{command: op, char_code: ch, target_col: c, target_row: r};
    start_i <= 1'b1;
    cmd_i   <= it;
    do @(posedge clk_i); while (busy_o);
    board.note_command(it);
    if (gaps && $urandom_range(0, 2) != 0) idle_gap();
  endtask

  task automatic drop_start();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register writes happen only with the block drained.
  task automatic drain();
    drop_start();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_REVERSE: board.cfg.reverse_video = val;
      REG_CURSOR:  board.cfg.cursor_enable = val;
      REG_SCROLL:  board.cfg.scroll_enable = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic rev, logic cur, logic scr);
    drain();
    write_reg(REG_REVERSE, rev);
    write_reg(REG_CURSOR, cur);
    write_reg(REG_SCROLL, scr);
  endtask

  // Random command mix; text-heavy so the cursor wraps and scrolls.
  task automatic random_command();
    int p;
    logic [7:0] ch;
    p = $urandom_range(0, 99);
    if (p < 70) begin
      ch = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) ch = CHAR_LF;
      else if ($urandom_range(0, 19) == 0) ch = CHAR_EOL;
      else if ($urandom_range(0, 19) == 0) ch = CHAR_CR;
      send_command(CMD_PUT, ch, 6'($urandom), 5'($urandom));
    end else if (p < 82) begin
      // occasional out-of-range targets exercise saturation
      send_command(CMD_GOTO, 8'($urandom),
                   ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, 39)),
                   ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23)));
    end else if (p < 83) begin
      send_command(CMD_CLEAR, 8'($urandom), 6'($urandom), 5'($urandom));
    end else begin
      send_command(CMD_READ, 8'($urandom),
                   ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 39)),
                   ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23)));
    end
  endtask

  initial begin
    board = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: special characters, wrap, scroll, saturation, reads.
    send_command(CMD_PUT, 8'h41, 6'd0, 5'd0);
    send_command(CMD_PUT, 8'hff, 6'd0, 5'd0);
    send_command(CMD_PUT, 8'h00, 6'd0, 5'd0);
    send_command(CMD_PUT, CHAR_CR, 6'd0, 5'd0);
    send_command(CMD_PUT, CHAR_LF, 6'd0, 5'd0);
    send_command(CMD_PUT, CHAR_EOL, 6'd0, 5'd0);
    send_command(CMD_READ, 8'h00, 6'd0, 5'd0);
    send_command(CMD_READ, 8'h00, 6'd63, 5'd31);
    send_command(CMD_GOTO, 8'h00, 6'd63, 5'd31);
    send_command(CMD_PUT, 8'h9f, 6'd0, 5'd0);  // wrap on last cell, scroll
    send_command(CMD_READ, 8'h00, 6'd39, 5'd22);
    send_command(CMD_GOTO, 8'h00, 6'd39, 5'd23);
    send_command(CMD_PUT, CHAR_LF, 6'd0, 5'd0);
    send_command(CMD_GOTO, 8'h00, 6'd0, 5'd0);
    send_command(CMD_READ, 8'h00, 6'd39, 5'd23);
    send_command(CMD_CLEAR, 8'h00, 6'd0, 5'd0);
    send_command(CMD_READ, 8'h00, 6'd0, 5'd0);

    // Extremes of the configuration, including no-scroll homing.
    set_config(1'b1, 1'b0, 1'b0);
    send_command(CMD_PUT, 8'h60, 6'd0, 5'd0);
    send_command(CMD_GOTO, 8'h00, 6'd5, 5'd23);
    send_command(CMD_PUT, CHAR_EOL, 6'd0, 5'd0);
    send_command(CMD_READ, 8'h00, 6'd0, 5'd0);
    set_config(1'b0, 1'b1, 1'b1);  // cursor reappears while drawn state changed

    // Random phases, each under its own setting.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0)
        set_config(1'($urandom), ($urandom_range(0, 3) != 0), 1'($urandom));
      for (int i = 0; i < 160; i++) begin
        random_command();
        if (ph == 3 && i == 80) drain();  // sender waits for all results
      end
    end

    drain();
    if (board.errors == 0)
      $display("[text_console_char_writer_top] OK");
    else
      $display("[text_console_char_writer_top] ERROR");
    $finish;
  end

  // Clears and scrolls sweep the whole store; even if every command swept the
  // store, the run would end well inside this limit.
  initial begin
    #100ms;
    $display("[text_console_char_writer_top] ERROR");
    $finish;
  end

endmodule
